[rtl/core/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// ARP responder and cache package
// Shared codes, field constants and reset values for the ARP responder core.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Default sizing of the host-part cache.
  localparam int unsigned CacheEntriesDef = 10;
  localparam int unsigned HostBitsDef     = 8;

  // Field widths fixed by the ARP format.
  localparam int unsigned MacW = 48;
  localparam int unsigned IpW  = 32;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_BUILD  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_OWN_IP   = 2'd0,
    CFG_OWN_MAC  = 2'd1,
    CFG_NET_MASK = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_REPLIED     = 4'd0,
    ST_MALFORMED   = 4'd1,
    ST_NOT_FOR_US  = 4'd2,
    ST_LEARNED     = 4'd3,
    ST_FOREIGN     = 4'd4,
    ST_UNKNOWN_OP  = 4'd5,
    ST_HIT         = 4'd6,
    ST_MISS        = 4'd7,
    ST_REQ_BUILT   = 4'd8
  } status_e;

  // Operation codes of outgoing packets.
  typedef enum logic [1:0] {
    OUT_OP_NONE    = 2'd0,
    OUT_OP_REQUEST = 2'd1,
    OUT_OP_REPLY   = 2'd2
  } out_op_e;

  // Fixed header values of an Ethernet/IPv4 ARP packet.
  localparam logic [10:0] ArpLength    = 11'd28;
  localparam logic [15:0] HwTypeEth    = 16'h0001;
  localparam logic [15:0] ProtoTypeIp4 = 16'h0800;
  localparam logic [7:0]  HwLenEth     = 8'd6;
  localparam logic [7:0]  ProtoLenIp4  = 8'd4;
  localparam logic [15:0] OpRequest    = 16'h0001;
  localparam logic [15:0] OpReply      = 16'h0002;

  localparam logic [MacW-1:0] MacBroadcast = {MacW{1'b1}};

  // Register reset values.
  localparam logic [IpW-1:0] OwnIpRst   = 32'h0000_0000;
  localparam logic [IpW-1:0] NetMaskRst = 32'hFFFF_FF00;

endpackage

[rtl/core/arp_responder_and_cache_core.sv]
// ----------------------------------------------------------------------------
// ARP responder and cache core
// Checks received ARP packets, answers requests, learns replies from the own
// subnet into a small round-robin cache, serves lookups and builds requests.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Beat contents
//  ---------+----------------------+------------------------------------------
//  item in  | start, busy          | kind_i .. target_ip_i
//  result   | done_o (1-cycle)     | send_packet_o .. status_o
//  config   | cfg_we_i, cfg_idx_i  | cfg_wdata_i (own_ip, own_mac, net_mask)
//
// A packet that needs no cache access (reply, build, rejects) gives its
// result in the cycle after acceptance. A lookup or a learned reply scans the
// cache one entry per cycle through the single registered read port of the
// cache memory and its one host comparator, and stops early on a hit. busy is
// high during the scan. Reset clears the valid bits at once, so no clearing
// pass is needed. The result beat cannot be stalled.
module arp_responder_and_cache_core #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CacheEntriesDef,
  parameter int unsigned HOST_BITS     = arpc_pkg::HostBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  // Item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [10:0] packet_length_i,
  input  logic [15:0] hardware_type_i,
  input  logic [15:0] protocol_type_i,
  input  logic [7:0]  hw_addr_len_i,
  input  logic [7:0]  proto_addr_len_i,
  input  logic [15:0] operation_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  // Result output
  output logic        done_o,
  output logic        send_packet_o,
  output logic [1:0]  out_operation_o,
  output logic [47:0] out_target_mac_o,
  output logic [31:0] out_target_ip_o,
  output logic        found_o,
  output logic [47:0] found_mac_o,
  output logic [3:0]  status_o
);

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [31:0] own_ip_q;
  logic [31:0] net_mask_q;

  // Cache memory and per-entry valid bits
  logic [HOST_BITS-1:0] host_mem [CACHE_ENTRIES];
  logic [47:0]          mac_mem  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vld_q;
  logic [HOST_BITS-1:0] rd_host_q;
  logic [47:0]          rd_mac_q;
  logic                 rd_vld_q;

  // Scan sequencer
  logic [IdxW-1:0]      addr_q;
  logic [IdxW-1:0]      pidx_q;
  logic                 pend_q;
  logic                 learn_q;
  logic [HOST_BITS-1:0] host_q;
  logic [47:0]          mac_q;
  logic [IdxW-1:0]      wp_q;

  // Result registers
  logic        done_q;
  logic        send_q;
  logic [1:0]  oop_q;
  logic [47:0] otmac_q;
  logic [31:0] otip_q;
  logic        found_q;
  logic [47:0] fmac_q;
  logic [3:0]  status_q;

  // Decode of an incoming item
  logic                 malformed;
  logic                 need_scan;
  logic                 need_learn;
  logic [31:0]          scan_ip;
  logic [31:0]          host_full;
  logic [HOST_BITS-1:0] scan_host;
  logic                 f_send;
  logic [1:0]           f_op;
  logic [47:0]          f_mac;
  logic [31:0]          f_ip;
  logic [3:0]           f_status;

  // Scan comparison
  logic [HOST_BITS-1:0] rd_host_eff;
  logic [47:0]          rd_mac_eff;
  logic                 hit;
  logic                 miss;
  logic                 finish;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;

  assign busy = (state_q != S_IDLE);

  // Configuration writes; the own MAC is not stored in this core.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q   <= arpc_pkg::OwnIpRst;
      net_mask_q <= arpc_pkg::NetMaskRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arpc_pkg::CFG_OWN_IP:   own_ip_q   <= cfg_wdata_i[31:0];
        arpc_pkg::CFG_NET_MASK: net_mask_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Header checks and the results that need no cache access.
  always_comb begin
    malformed  = (packet_length_i != arpc_pkg::ArpLength)
              || (hardware_type_i != arpc_pkg::HwTypeEth)
              || (protocol_type_i != arpc_pkg::ProtoTypeIp4)
              || (hw_addr_len_i != arpc_pkg::HwLenEth)
              || (proto_addr_len_i != arpc_pkg::ProtoLenIp4);
    need_scan  = 1'b0;
    need_learn = 1'b0;
    f_send     = 1'b0;
    f_op       = arpc_pkg::OUT_OP_NONE;
    f_mac      = '0;
    f_ip       = '0;
    f_status   = arpc_pkg::ST_MALFORMED;
    scan_ip    = sender_ip_i;
    unique case (kind_i)
      arpc_pkg::KIND_PACKET: begin
        if (malformed) begin
          f_status = arpc_pkg::ST_MALFORMED;
        end else if (target_ip_i != own_ip_q) begin
          f_status = arpc_pkg::ST_NOT_FOR_US;
        end else if (operation_i == arpc_pkg::OpRequest) begin
          f_send   = 1'b1;
          f_op     = arpc_pkg::OUT_OP_REPLY;
          f_mac    = sender_mac_i;
          f_ip     = sender_ip_i;
          f_status = arpc_pkg::ST_REPLIED;
        end else if (operation_i == arpc_pkg::OpReply) begin
          if ((sender_ip_i & net_mask_q) != (own_ip_q & net_mask_q)) begin
            f_status = arpc_pkg::ST_FOREIGN;
          end else begin
            need_scan  = 1'b1;
            need_learn = 1'b1;
          end
        end else begin
          f_status = arpc_pkg::ST_UNKNOWN_OP;
        end
      end
      arpc_pkg::KIND_LOOKUP: begin
        need_scan = 1'b1;
        scan_ip   = target_ip_i;
      end
      arpc_pkg::KIND_BUILD: begin
        f_send   = 1'b1;
        f_op     = arpc_pkg::OUT_OP_REQUEST;
        f_mac    = arpc_pkg::MacBroadcast;
        f_ip     = target_ip_i;
        f_status = arpc_pkg::ST_REQ_BUILT;
      end
      default: begin
        f_status = arpc_pkg::ST_MALFORMED;
      end
    endcase
    host_full = scan_ip & ~net_mask_q;
    scan_host = host_full[HOST_BITS-1:0];
  end

  // An entry that was never written reads as host zero with MAC zero.
  always_comb begin
    rd_host_eff = rd_vld_q ? rd_host_q : '0;
    rd_mac_eff  = rd_vld_q ? rd_mac_q : '0;
    hit         = pend_q && (rd_host_eff == host_q);
    miss        = pend_q && !hit && (pidx_q == LastIdx);
    finish      = (state_q == S_SCAN) && (hit || miss);
    mem_we      = finish && learn_q;
    mem_waddr   = hit ? pidx_q : wp_q;
  end

  // Cache memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      host_mem[mem_waddr] <= host_q;
      mac_mem[mem_waddr]  <= mac_q;
    end
    rd_host_q <= host_mem[addr_q];
    rd_mac_q  <= mac_mem[addr_q];
  end

  // Sequencer, valid bits and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      addr_q   <= '0;
      pidx_q   <= '0;
      pend_q   <= 1'b0;
      learn_q  <= 1'b0;
      host_q   <= '0;
      mac_q    <= '0;
      wp_q     <= '0;
      done_q   <= 1'b0;
      send_q   <= 1'b0;
      oop_q    <= arpc_pkg::OUT_OP_NONE;
      otmac_q  <= '0;
      otip_q   <= '0;
      found_q  <= 1'b0;
      fmac_q   <= '0;
      status_q <= arpc_pkg::ST_REPLIED;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= vld_q[addr_q];
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (need_scan) begin
              state_q <= S_SCAN;
              addr_q  <= '0;
              pend_q  <= 1'b0;
              learn_q <= need_learn;
              host_q  <= scan_host;
              mac_q   <= sender_mac_i;
            end else begin
              done_q   <= 1'b1;
              send_q   <= f_send;
              oop_q    <= f_op;
              otmac_q  <= f_mac;
              otip_q   <= f_ip;
              found_q  <= 1'b0;
              fmac_q   <= '0;
              status_q <= f_status;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            state_q <= S_IDLE;
            pend_q  <= 1'b0;
            done_q  <= 1'b1;
            send_q  <= 1'b0;
            oop_q   <= arpc_pkg::OUT_OP_NONE;
            otmac_q <= '0;
            otip_q  <= '0;
            if (learn_q) begin
              vld_q[mem_waddr] <= 1'b1;
              found_q          <= 1'b0;
              fmac_q           <= '0;
              status_q         <= arpc_pkg::ST_LEARNED;
              // A new host takes the round-robin slot.
              if (miss) begin
                wp_q <= (wp_q == LastIdx) ? '0 : wp_q + IdxW'(1);
              end
            end else begin
              found_q  <= hit;
              fmac_q   <= hit ? rd_mac_eff : '0;
              status_q <= hit ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
            end
          end else begin
            // Issue the next read; the last entry is read only once.
            pend_q <= 1'b1;
            pidx_q <= addr_q;
            if (addr_q != LastIdx) begin
              addr_q <= addr_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o           = done_q;
  assign send_packet_o    = send_q;
  assign out_operation_o  = oop_q;
  assign out_target_mac_o = otmac_q;
  assign out_target_ip_o  = otip_q;
  assign found_o          = found_q;
  assign found_mac_o      = fmac_q;
  assign status_o         = status_q;

`ifndef SYNTHESIS
  // A result beat follows either a direct item or the end of a scan.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(finish)))
    else $error("result beat without a cause");

  // A hit is only ever reported with the hit status.
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (status_o == arpc_pkg::ST_HIT))
    else $error("found set with wrong status");

  // The replacement pointer stays inside the cache.
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LastIdx)
    else $error("write pointer out of range");

  // The cache is written only while a learned reply finishes its scan.
  a_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (done_o && status_o == arpc_pkg::ST_LEARNED))
    else $error("cache write without a learned result");
`endif

endmodule
